// ===== hw/rtl/stw_pkg.sv =====
// Types and codes shared by the stopwatch timer bank.
package stw_pkg;

    typedef enum logic [2:0] {
        MODE_TICK   = 3'd0,
        MODE_START  = 3'd1,
        MODE_PAUSE  = 3'd2,
        MODE_RESUME = 3'd3,
        MODE_STOP   = 3'd4,
        MODE_READ   = 3'd5,
        MODE_RESET  = 3'd6
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic [63:0] start_stamp;
        logic [63:0] end_stamp;
        logic [63:0] pause_stamp;
        logic        paused_flag;
    } entry_t;

endpackage

// ===== hw/rtl/stopwatch_timer_bank_top.sv =====
// Stopwatch timer bank: shared tick counter and one timer entry memory.
// A tick request increments the tick counter and leaves busy low.
// A timer request reads its entry on acceptance, then passes through LOAD, and also UPDATE
// for resume or stop of a paused timer: LOAD takes the 64-bit pause span, UPDATE adds it.
// A read result appears on elapsed_ticks with done in the cycle in which busy falls.
// Reset clears the counter and marks every timer entry as zero through per-entry valid bits.
module stopwatch_timer_bank_top
    import stw_pkg::*;
#(
    parameter int NUM_TIMERS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [2:0]  mode,
    input  logic [4:0]  timer_index,
    output logic        busy,
    output logic        done,
    output logic [63:0] elapsed_ticks
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam logic [5:0] NUM_T = 6'(NUM_TIMERS);

    state_t                state_reg;
    state_t                state_next;
    logic [63:0]           tick_now_reg;
    mode_t                 mode_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic                  idx_ok_reg;
    entry_t                rd_entry_reg;
    logic                  rd_valid_reg;
    logic [63:0]           diff_reg;
    logic                  done_reg;
    logic [63:0]           elapsed_reg;
    logic [NUM_TIMERS-1:0] valid_reg;

    entry_t                mem [NUM_TIMERS];

    logic                  accept;
    logic                  cmd_go;
    logic [IDX_W-1:0]      in_idx;
    entry_t                cur;
    logic                  wr_en;
    entry_t                wr_data;
    logic                  res_en;
    logic [63:0]           res_value;
    logic [63:0]           stop_point;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign cmd_go = accept && (mode != MODE_TICK) && (mode <= MODE_RESET);
    assign in_idx = timer_index[IDX_W-1:0];
    assign cur    = rd_valid_reg ? rd_entry_reg : '0;

    assign done          = done_reg;
    assign elapsed_ticks = elapsed_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_go)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_IDLE;
                if (idx_ok_reg && cur.paused_flag &&
                    (mode_reg == MODE_RESUME || mode_reg == MODE_STOP))
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        wr_en      = 1'b0;
        wr_data    = cur;
        res_en     = 1'b0;
        res_value  = '0;
        stop_point = (cur.end_stamp != 64'd0) ? cur.end_stamp : tick_now_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (mode_reg == MODE_READ)
                begin
                    res_en = 1'b1;
                    if (idx_ok_reg)
                    begin
                        res_value = stop_point - cur.start_stamp;
                    end
                end
                else if (idx_ok_reg)
                begin
                    case (mode_reg)
                        MODE_START:
                        begin
                            wr_en               = 1'b1;
                            wr_data.start_stamp = tick_now_reg;
                            wr_data.pause_stamp = '0;
                            wr_data.paused_flag = 1'b0;
                        end
                        MODE_PAUSE:
                        begin
                            if (!cur.paused_flag)
                            begin
                                wr_en               = 1'b1;
                                wr_data.pause_stamp = tick_now_reg;
                                wr_data.paused_flag = 1'b1;
                            end
                        end
                        MODE_STOP:
                        begin
                            if (!cur.paused_flag)
                            begin
                                wr_en             = 1'b1;
                                wr_data.end_stamp = tick_now_reg;
                            end
                        end
                        MODE_RESET:
                        begin
                            wr_en   = 1'b1;
                            wr_data = '0;
                        end
                        default:
                        begin
                            wr_en = 1'b0;
                        end
                    endcase
                end
            end
            ST_UPDATE:
            begin
                wr_en               = 1'b1;
                wr_data.start_stamp = cur.start_stamp + diff_reg;
                wr_data.paused_flag = 1'b0;
                if (mode_reg == MODE_STOP)
                begin
                    wr_data.end_stamp = tick_now_reg;
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            tick_now_reg <= '0;
            valid_reg    <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= res_en;
            if (accept && mode == MODE_TICK)
            begin
                tick_now_reg <= tick_now_reg + 64'd1;
            end
            if (wr_en)
            begin
                valid_reg[idx_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_go)
        begin
            mode_reg     <= mode_t'(mode);
            idx_reg      <= in_idx;
            idx_ok_reg   <= ({1'b0, timer_index} < NUM_T);
            rd_entry_reg <= mem[in_idx];
            rd_valid_reg <= valid_reg[in_idx];
        end
        if (state_reg == ST_LOAD)
        begin
            diff_reg <= tick_now_reg - cur.pause_stamp;
        end
        if (res_en)
        begin
            elapsed_reg <= res_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[idx_reg] <= wr_data;
        end
    end

endmodule
